### sv/mprq_pkg.sv
// Shared types and fixed field widths for the multilevel priority run queue.
package mprq_pkg;

  localparam int REQ_W   = 2;
  localparam int TASK_W  = 6;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_STEAL = 2'd2
  } req_code_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [TASK_W-1:0]        task_id;
    logic signed [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic [TASK_W-1:0]        task_out;
    logic [COUNT_W-1:0]       queued_count;
  } rsp_t;

endpackage

### sv/mprq_req_if.sv
// Request channel: valid/ready handshake carrying one queue request.
interface mprq_req_if import mprq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [TASK_W-1:0]        task_id;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, output req_type, output task_id, output priority_req,
                  input ready);
  modport sink   (input valid, input req_type, input task_id, input priority_req,
                  output ready);
endinterface

### sv/mprq_rsp_if.sv
// Result channel: valid/ready handshake carrying one request result.
interface mprq_rsp_if import mprq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [TASK_W-1:0]  task_out;
  logic [COUNT_W-1:0] queued_count;

  modport source (output valid, output found, output task_out, output queued_count,
                  input ready);
  modport sink   (input valid, input found, input task_out, input queued_count,
                  output ready);
endinterface

### sv/multilevel_priority_run_queue_unit.sv
// Multilevel priority run queue: one linked FIFO of task slots per priority level.
//
// in_req carries one request per transfer: enqueue a task slot at a level,
// dequeue the head of the most urgent non-empty level (level 0 first), or
// steal the head of the least urgent non-empty level. out_rsp returns one
// result per request: found, the removed slot and the queued count after it.
// A request is taken into an input register; when it advances, the queue is
// updated and the result is written to the output register. One request is
// taken every cycle while out_rsp is not stalled. The task links live in a
// RAM with registered read; the new head after a pop is forwarded from the
// RAM read data to the next request, which keeps back-to-back pops on one
// level at one per cycle.
// Reset (synchronous, rst_n low) empties every level and clears the count.
// When out_rsp is stalled the result register holds, the input register
// still takes one more request, and in_req.ready then drops until the
// result is taken.
module multilevel_priority_run_queue_unit import mprq_pkg::*; #(
  parameter int NUM_LEVELS = 8,
  parameter int NUM_TASKS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  mprq_req_if.sink   in_req,
  mprq_rsp_if.source out_rsp
);
  logic in_valid_r;
  req_t in_item_r;
  logic out_valid_r;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic advance;

  assign advance      = in_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_req.ready) in_valid_r <= in_req.valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      in_item_r.req_type     <= in_req.req_type;
      in_item_r.task_id      <= in_req.task_id;
      in_item_r.priority_req <= in_req.priority_req;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  mprq_core #(
    .NUM_LEVELS (NUM_LEVELS),
    .NUM_TASKS  (NUM_TASKS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .rsp     (rsp)
  );

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.found        = out_rsp_r.found;
  assign out_rsp.task_out     = out_rsp_r.task_out;
  assign out_rsp.queued_count = out_rsp_r.queued_count;
endmodule

### sv/mprq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mprq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/mprq_core.sv
// Queue state and the single-pass enqueue / dequeue / steal update.
module mprq_core import mprq_pkg::*; #(
  parameter int NUM_LEVELS = 8,
  parameter int NUM_TASKS  = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  req_t item,
  output rsp_t rsp
);
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);

  logic [NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [NUM_TASKS-1:0]  present_r, present_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  pend_r, pend_nxt;
  logic [LW-1:0]         pend_lvl_r;
  logic [IW-1:0]         head_r [NUM_LEVELS];
  logic [IW-1:0]         tail_r [NUM_LEVELS];

  logic [LW-1:0] enq_lvl, lo_lvl, hi_lvl, pop_lvl;
  logic [IW-1:0] enq_t, head_sel, tout;
  logic          enq_ok, any_ne, has_next, found;
  logic          head_we, tail_we, ram_we;
  logic [IW-1:0] ram_rdata;

  // level mapping: negative or too large goes to the least urgent level
  always_comb begin
    if (item.priority_req[PRIO_W-1] ||
        ({1'b0, item.priority_req[PRIO_W-2:0]} >= PRIO_W'(NUM_LEVELS))) begin
      enq_lvl = LW'(NUM_LEVELS - 1);
    end else begin
      enq_lvl = LW'(item.priority_req[PRIO_W-2:0]);
    end
    enq_t  = IW'(item.task_id);
    enq_ok = int'(item.task_id) < NUM_TASKS;
  end

  always_comb begin
    lo_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) lo_lvl = LW'(i);
    end
    hi_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty_r[i]) hi_lvl = LW'(i);
    end
  end

  assign any_ne  = |nonempty_r;
  assign pop_lvl = (item.req_type == REQ_STEAL) ? hi_lvl : lo_lvl;
  // new head after last cycle's pop is still arriving from the link RAM
  assign head_sel = (pend_r && pend_lvl_r == pop_lvl) ? ram_rdata : head_r[pop_lvl];
  assign has_next = present_r[head_sel];

  always_comb begin
    nonempty_nxt = nonempty_r;
    present_nxt  = present_r;
    count_nxt    = count_r;
    pend_nxt     = 1'b0;
    head_we      = 1'b0;
    tail_we      = 1'b0;
    ram_we       = 1'b0;
    found        = 1'b0;
    tout         = '0;
    case (item.req_type)
      REQ_ENQ: begin
        if (enq_ok) begin
          present_nxt[enq_t] = 1'b0;
          if (!nonempty_r[enq_lvl]) begin
            head_we               = 1'b1;
            nonempty_nxt[enq_lvl] = 1'b1;
          end else begin
            ram_we                          = 1'b1;
            present_nxt[tail_r[enq_lvl]] = 1'b1;
          end
          tail_we = 1'b1;
          if (count_r < CW'(NUM_TASKS)) count_nxt = count_r + 1'b1;
        end
      end
      REQ_DEQ, REQ_STEAL: begin
        if (any_ne) begin
          found = 1'b1;
          tout  = head_sel;
          if (has_next) begin
            pend_nxt = 1'b1;
          end else begin
            nonempty_nxt[pop_lvl] = 1'b0;
          end
          present_nxt[head_sel] = 1'b0;
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
      present_r  <= '0;
      count_r    <= '0;
      pend_r     <= 1'b0;
    end else begin
      pend_r <= advance && pend_nxt;
      if (advance) begin
        nonempty_r <= nonempty_nxt;
        present_r  <= present_nxt;
        count_r    <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_lvl_r <= pop_lvl;
    if (pend_r) begin
      head_r[pend_lvl_r] <= ram_rdata;
    end
    if (advance && head_we) begin
      head_r[enq_lvl] <= enq_t;
    end
    if (advance && tail_we) begin
      tail_r[enq_lvl] <= enq_t;
    end
  end

  mprq_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_TASKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (advance && ram_we),
    .waddr (tail_r[enq_lvl]),
    .wdata (enq_t),
    .raddr (head_sel),
    .rdata (ram_rdata)
  );

  assign rsp.found        = found;
  assign rsp.task_out     = TASK_W'(tout);
  assign rsp.queued_count = COUNT_W'(count_nxt);
endmodule

### tb/mprq_result_checker.sv
// Run queue checker: predicts each result from request transfers and compares result transfers.
module mprq_result_checker import mprq_pkg::*; #(
  parameter int NUM_LEVELS = 8,
  parameter int NUM_TASKS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  mprq_req_if         req_mon,
  mprq_rsp_if         rsp_mon,
  output int unsigned mismatches,
  output int unsigned awaiting,
  output int unsigned checked,
  output int unsigned removed,
  output int unsigned empty_removals,
  output int unsigned full_seen
);

  logic              lvl_busy  [NUM_LEVELS];
  logic [TASK_W-1:0] lvl_first [NUM_LEVELS];
  logic [TASK_W-1:0] lvl_last  [NUM_LEVELS];
  logic [TASK_W-1:0] succ      [NUM_TASKS];
  logic              succ_ok   [NUM_TASKS];
  int unsigned       depth;
  rsp_t              expected_rsp[$];

  function automatic logic [TASK_W-1:0] take_head(int lvl);
    logic [TASK_W-1:0] t;
    t = TASK_W'(lvl_first[lvl] % NUM_TASKS);
    if (succ_ok[t]) begin
      lvl_first[lvl] = TASK_W'(succ[t] % NUM_TASKS);
    end else begin
      lvl_busy[lvl] = 1'b0;
    end
    succ_ok[t] = 1'b0;
    if (depth > 0) begin
      depth--;
    end
    return t;
  endfunction

  function automatic void put_tail(int lvl, logic [TASK_W-1:0] t);
    logic [TASK_W-1:0] last;
    succ_ok[t] = 1'b0;
    if (!lvl_busy[lvl]) begin
      lvl_first[lvl] = t;
      lvl_last[lvl]  = t;
      lvl_busy[lvl]  = 1'b1;
    end else begin
      last = TASK_W'(lvl_last[lvl] % NUM_TASKS);
      succ[last]    = t;
      succ_ok[last] = 1'b1;
      lvl_last[lvl] = t;
    end
    if (depth < NUM_TASKS) begin
      depth++;
    end
  endfunction

  function automatic rsp_t run_queue_step(logic [REQ_W-1:0] kind, logic [TASK_W-1:0] tid,
                                          logic signed [PRIO_W-1:0] prio);
    rsp_t r;
    int   lvl;
    logic hit;
    r.found    = 1'b0;
    r.task_out = '0;
    hit        = 1'b0;
    case (kind)
      REQ_ENQ: begin
        if (prio < 0 || prio >= NUM_LEVELS) begin
          lvl = NUM_LEVELS - 1;
        end else begin
          lvl = int'(prio);
        end
        if (tid < NUM_TASKS) begin
          put_tail(lvl, tid);
        end
      end
      REQ_DEQ: begin
        for (int i = 0; i < NUM_LEVELS && !hit; i++) begin
          if (lvl_busy[i]) begin
            r.task_out = take_head(i);
            hit = 1'b1;
          end
        end
      end
      REQ_STEAL: begin
        for (int i = NUM_LEVELS - 1; i >= 0 && !hit; i--) begin
          if (lvl_busy[i]) begin
            r.task_out = take_head(i);
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.found        = hit;
    r.queued_count = COUNT_W'(depth);
    if (hit) begin
      removed++;
    end else if (kind == REQ_DEQ || kind == REQ_STEAL) begin
      empty_removals++;
    end
    if (depth == NUM_TASKS) begin
      full_seen++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("[%0t] result %0d: %s got %0d want %0d", $time, checked, what, got, want);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lvl_busy[i] = 1'b0;
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
        succ_ok[i] = 1'b0;
      end
      depth          = 0;
      mismatches     = 0;
      checked        = 0;
      removed        = 0;
      empty_removals = 0;
      full_seen      = 0;
      expected_rsp.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("transfer with nothing outstanding, task_out", rsp_mon.task_out, 0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_mon.found !== want.found) begin
            report_mismatch("found", rsp_mon.found, want.found);
          end
          if (rsp_mon.task_out !== want.task_out) begin
            report_mismatch("task_out", rsp_mon.task_out, want.task_out);
          end
          if (rsp_mon.queued_count !== want.queued_count) begin
            report_mismatch("queued_count", rsp_mon.queued_count, want.queued_count);
          end
        end
        checked++;
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_rsp.push_back(run_queue_step(req_mon.req_type, req_mon.task_id,
                                              req_mon.priority_req));
      end
    end
    awaiting <= expected_rsp.size();
  end

endmodule

### tb/multilevel_priority_run_queue_unit_test.sv
// Testbench top for the run queue: reset, request stimulus, result back-pressure and verdict.
module multilevel_priority_run_queue_unit_test;
  import mprq_pkg::*;

  localparam int NUM_LEVELS   = 8;
  localparam int NUM_TASKS    = 64;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 500;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  mprq_req_if in_req ();
  mprq_rsp_if out_rsp ();

  int unsigned mismatches, awaiting, checked, removed, empty_removals, full_seen;
  int unsigned sent, far_levels, unused_codes;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  logic        hold_on;
  logic        on_queue [NUM_TASKS];

  multilevel_priority_run_queue_unit #(
    .NUM_LEVELS(NUM_LEVELS),
    .NUM_TASKS (NUM_TASKS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  mprq_result_checker #(
    .NUM_LEVELS(NUM_LEVELS),
    .NUM_TASKS (NUM_TASKS)
  ) result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (in_req),
    .rsp_mon       (out_rsp),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .checked       (checked),
    .removed       (removed),
    .empty_removals(empty_removals),
    .full_seen     (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, awaiting);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // slots seen leaving the queue become free for new enqueues
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready && out_rsp.found) begin
      on_queue[out_rsp.task_out] = 1'b0;
    end
  end

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [TASK_W-1:0] tid,
                          input logic signed [PRIO_W-1:0] prio);
    in_req.valid        <= 1'b1;
    in_req.req_type     <= kind;
    in_req.task_id      <= tid;
    in_req.priority_req <= prio;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent++;
    if (kind == REQ_ENQ) begin
      on_queue[tid] = 1'b1;
      if (prio < 0 || prio >= NUM_LEVELS) begin
        far_levels++;
      end
    end else if (kind == REQ_UNUSED) begin
      unused_codes++;
    end
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = hold_on ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  function automatic logic [TASK_W-1:0] pick_slot();
    logic [TASK_W-1:0] t;
    logic              ok;
    ok = 1'b0;
    t  = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    if ($urandom_range(0, 99) >= 3) begin
      for (int k = 0; k < 12 && !ok; k++) begin
        t  = TASK_W'($urandom_range(0, NUM_TASKS - 1));
        ok = !on_queue[t];
      end
    end
    return t;
  endfunction

  task automatic random_item(input int unsigned mix, output logic counted);
    int unsigned              roll, enq_pct, steal_pct;
    logic [REQ_W-1:0]         kind;
    logic [TASK_W-1:0]        tid;
    logic signed [PRIO_W-1:0] prio;
    case (mix)
      0: begin enq_pct = 55; steal_pct = 40; end
      1: begin enq_pct = 85; steal_pct = 50; end
      2: begin enq_pct = 20; steal_pct = 30; end
      default: begin enq_pct = 50; steal_pct = 75; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      kind = REQ_UNUSED;
    end else if (roll < 4 + enq_pct) begin
      kind = REQ_ENQ;
    end else if ($urandom_range(0, 99) < steal_pct) begin
      kind = REQ_STEAL;
    end else begin
      kind = REQ_DEQ;
    end
    tid = (kind == REQ_ENQ) ? pick_slot() : TASK_W'($urandom_range(0, NUM_TASKS - 1));
    if ($urandom_range(0, 99) < 85) begin
      prio = PRIO_W'($urandom_range(0, NUM_LEVELS - 1));
    end else begin
      prio = PRIO_W'($urandom_range(0, 255));
    end
    pace();
    send_req(kind, tid, prio);
    counted = (kind != REQ_UNUSED);
  endtask

  // receiver: spans of different ready patterns, plus one long hold-off
  initial begin
    int unsigned mode, span;
    logic        hold_done;
    hold_done = 1'b0;
    hold_on   = 1'b0;
    out_rsp.ready <= 1'b0;
    forever begin
      if (!hold_done && sent >= HOLD_AFTER) begin
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_rsp.ready <= 1'b0;
        end
        hold_on   = 1'b0;
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0: out_rsp.ready <= 1'b1;
          1: out_rsp.ready <= ($urandom_range(0, 1) == 1);
          2: out_rsp.ready <= ($urandom_range(0, 99) < 85);
          default: out_rsp.ready <= (k % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned meaningful, mix;
    logic        counted;
    sent         = 0;
    far_levels   = 0;
    unused_codes = 0;
    burst_left   = 0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      on_queue[i] = 1'b0;
    end
    rst_n               <= 1'b0;
    in_req.valid        <= 1'b0;
    in_req.req_type     <= REQ_ENQ;
    in_req.task_id      <= '0;
    in_req.priority_req <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(REQ_DEQ,    6'd0,  8'sd0);
    send_req(REQ_STEAL,  6'd63, 8'shff);
    send_req(REQ_UNUSED, 6'd42, 8'sh55);
    send_req(REQ_ENQ,    6'd0,  8'sd0);
    send_req(REQ_ENQ,    6'd63, 8'sd7);
    send_req(REQ_ENQ,    6'd21, 8'sh80);
    send_req(REQ_ENQ,    6'd42, 8'sh7f);
    send_req(REQ_ENQ,    6'd5,  8'sd8);
    send_req(REQ_ENQ,    6'd9,  8'shff);
    send_req(REQ_ENQ,    6'd33, 8'sd3);
    send_req(REQ_ENQ,    6'd17, 8'sd1);
    send_req(REQ_STEAL,  6'd0,  8'sd0);
    send_req(REQ_DEQ,    6'd63, 8'sh80);
    send_req(REQ_DEQ,    6'd0,  8'sd0);
    send_req(REQ_DEQ,    6'd0,  8'sd0);
    send_req(REQ_DEQ,    6'd0,  8'sd0);
    send_req(REQ_STEAL,  6'd0,  8'sd0);
    // slot 5 is still queued: relink it behind slot 9
    send_req(REQ_ENQ,    6'd5,  8'sd7);
    send_req(REQ_UNUSED, 6'd21, 8'sh2a);
    send_req(REQ_DEQ,    6'd0,  8'sd0);
    send_req(REQ_DEQ,    6'd0,  8'sd0);
    send_req(REQ_STEAL,  6'd0,  8'sd0);
    send_req(REQ_DEQ,    6'd0,  8'sd0);

    meaningful = 0;
    mix = 0;
    while (meaningful < RANDOM_ITEMS) begin
      if (meaningful % 120 == 0) begin
        mix = $urandom_range(0, 3);
      end
      random_item(mix, counted);
      if (counted) begin
        meaningful++;
      end
    end
    in_req.valid <= 1'b0;

    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("requests sent %0d (%0d enqueues at out-of-range levels, %0d unused codes)",
             sent, far_levels, unused_codes);
    $display("results checked %0d: %0d tasks removed, %0d removals from empty, %0d at full",
             checked, removed, empty_removals, full_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
